@@ hw/rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and fixed widths of the bilinear image sampler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH    = 256;  // widest image the store holds
  localparam int MAX_HEIGHT   = 256;  // tallest image the store holds
  localparam int MAX_CHANNELS = 4;    // channels per pixel at most

  localparam int COORD_W     = 18;  // sample coordinate, signed
  localparam int LADDR_W     = 18;  // load byte address
  localparam int PIX_W       = 8;   // one image byte
  localparam int OUT_W       = 16;  // result channel
  localparam int DIM_W       = 9;   // width/height register and pixel coordinate
  localparam int CNT_W       = 3;   // channel count register
  localparam int CH_W        = 2;   // channel index
  localparam int ROW_W       = 18;  // y*w
  localparam int IDX_W       = 20;  // (y*w+x)*n
  localparam int FRAC_MAX_W  = 12;  // widest fraction the design supports
  localparam int NUM_OUT_CH  = 4;
  localparam int NUM_NBR     = 4;
  localparam int QUEUE_DEPTH = 4;   // power of two
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  // Saturated configuration as the datapath sees it
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [CNT_W-1:0] count;
  } cfg_t;

  // One classified item between front and back
  typedef struct packed {
    logic                           is_load;
    logic [LADDR_W-1:0]             load_addr;
    logic [PIX_W-1:0]               load_val;
    logic                           in_image;
    logic [FRAC_MAX_W-1:0]          fx;
    logic [FRAC_MAX_W-1:0]          fy;
    logic [NUM_NBR-1:0][IDX_W-1:0]  base;   // y1x1, y1x2, y2x1, y2x2
  } entry_t;

  // Control travelling with a channel through the blend pipeline
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            in_image;
    logic [CH_W-1:0] ch;
  } tag_t;

endpackage

@@ hw/rtl/bis_queue.sv @@
// ----------------------------------------------------------------------------
// bis_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module bis_queue import bis_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] head_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]      slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ hw/rtl/bis_front.sv @@
// ----------------------------------------------------------------------------
// bis_front
// Accepts items, splits coordinates and forms the four neighbour addresses.
// ----------------------------------------------------------------------------
module bis_front import bis_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [LADDR_W-1:0]        load_address_i,
  input  logic [PIX_W-1:0]          load_value_i,
  input  logic signed [COORD_W-1:0] sample_x_i,
  input  logic signed [COORD_W-1:0] sample_y_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output entry_t                    entry_o
);

  typedef struct packed {
    logic                  ok;
    logic [DIM_W-1:0]      lo;
    logic [DIM_W-1:0]      hi;
    logic [FRAC_MAX_W-1:0] frac;
  } split_t;

  function automatic split_t split(logic [COORD_W-1:0] v, logic [DIM_W-1:0] lim);
    split_t                          s;
    logic [COORD_W-2-FRACTION_BITS:0] p;
    logic [FRAC_MAX_W-1:0]           f;
    logic                            at_edge;
    p         = v[COORD_W-2:FRACTION_BITS];
    f         = FRAC_MAX_W'(v[FRACTION_BITS-1:0]);
    s.ok      = !v[COORD_W-1] && (32'(p) < 32'(lim));
    s.lo      = DIM_W'(p);
    at_edge   = (f != '0) && ((32'(p) + 32'd1) == 32'(lim));
    s.hi      = (f != '0 && !at_edge) ? DIM_W'(p) + 1'b1 : DIM_W'(p);
    s.frac    = at_edge ? '0 : f;
    return s;
  endfunction

  logic   en;
  split_t sx, sy;

  // stage 1
  logic                  v1_q, load1_q, ok1_q;
  logic [LADDR_W-1:0]    la1_q;
  logic [PIX_W-1:0]      lv1_q;
  split_t                sx1_q, sy1_q;
  // stage 2
  logic                  v2_q, load2_q, ok2_q;
  logic [LADDR_W-1:0]    la2_q;
  logic [PIX_W-1:0]      lv2_q;
  logic [DIM_W-1:0]      x1_2_q, x2_2_q;
  logic [FRAC_MAX_W-1:0] fx2_q, fy2_q;
  logic [ROW_W-1:0]      r1_q, r2_q;
  // stage 3
  logic                  v3_q;
  entry_t                e3_q;

  assign en         = !(v3_q && q_full_i);
  assign in_stall_o = !en;
  assign push_o     = v3_q && !q_full_i;
  assign entry_o    = e3_q;

  assign sx = split(sample_x_i, cfg_i.width);
  assign sy = split(sample_y_i, cfg_i.height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      load1_q <= (action_i == ACT_LOAD);
      la1_q   <= load_address_i;
      lv1_q   <= load_value_i;
      sx1_q   <= sx;
      sy1_q   <= sy;
      ok1_q   <= sx.ok && sy.ok;

      load2_q <= load1_q;
      la2_q   <= la1_q;
      lv2_q   <= lv1_q;
      ok2_q   <= ok1_q;
      x1_2_q  <= sx1_q.lo;
      x2_2_q  <= sx1_q.hi;
      fx2_q   <= sx1_q.frac;
      fy2_q   <= sy1_q.frac;
      r1_q    <= ROW_W'(sy1_q.lo) * ROW_W'(cfg_i.width);
      r2_q    <= ROW_W'(sy1_q.hi) * ROW_W'(cfg_i.width);

      e3_q.is_load   <= load2_q;
      e3_q.load_addr <= la2_q;
      e3_q.load_val  <= lv2_q;
      e3_q.in_image  <= ok2_q;
      e3_q.fx        <= fx2_q;
      e3_q.fy        <= fy2_q;
      e3_q.base[0]   <= IDX_W'(r1_q + ROW_W'(x1_2_q)) * IDX_W'(cfg_i.count);
      e3_q.base[1]   <= IDX_W'(r1_q + ROW_W'(x2_2_q)) * IDX_W'(cfg_i.count);
      e3_q.base[2]   <= IDX_W'(r2_q + ROW_W'(x1_2_q)) * IDX_W'(cfg_i.count);
      e3_q.base[3]   <= IDX_W'(r2_q + ROW_W'(x2_2_q)) * IDX_W'(cfg_i.count);
    end
  end

endmodule

@@ hw/rtl/bis_back.sv @@
// ----------------------------------------------------------------------------
// bis_back
// Executes queued items: byte writes, per-channel neighbour reads, blends.
// ----------------------------------------------------------------------------
module bis_back import bis_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int MEM_DEPTH     = 262144
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  entry_t           q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OUT_W-1:0] channel_0_o,
  output logic [OUT_W-1:0] channel_1_o,
  output logic [OUT_W-1:0] channel_2_o,
  output logic [OUT_W-1:0] channel_3_o,
  output logic             inside_res_o
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int FB  = FRACTION_BITS;
  localparam int HW  = PIX_W + FB + 1;
  localparam int VW  = PIX_W + 2 * FB + 1;
  localparam int ONE = 1 << FB;

  logic                           adv, issue_last, wr_en;
  logic [CH_W-1:0]                ch_q;
  logic [NUM_NBR-1:0][AW-1:0]     rd_addr;
  logic [NUM_NBR-1:0][PIX_W-1:0]  rd_q;
  tag_t                           tag0, t1_q, t2_q, t3_q;
  logic [FB-1:0]                  fx1_q, fy1_q, fy2_q;
  logic [HW-1:0]                  top_q, bot_q;
  logic [OUT_W-1:0]               v3_q;
  logic [NUM_OUT_CH-1:0][OUT_W-1:0] acc_q, res_q;
  logic                           out_valid_q, in_image_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign issue_last = ({1'b0, ch_q} == (cfg_i.count - 1'b1));
  assign wr_en      = adv && q_valid_i && q_head_i.is_load &&
                      (32'(q_head_i.load_addr) < MEM_DEPTH);
  assign q_pop_o    = adv && q_valid_i &&
                      (q_head_i.is_load || !q_head_i.in_image || issue_last);

  always_comb begin
    tag0          = '0;
    tag0.valid    = q_valid_i && !q_head_i.is_load;
    tag0.in_image = q_head_i.in_image;
    tag0.last     = !q_head_i.in_image || issue_last;
    tag0.ch       = q_head_i.in_image ? ch_q : '0;
    for (int k = 0; k < NUM_NBR; k++) begin
      rd_addr[k] = AW'(q_head_i.base[k] + IDX_W'(ch_q));
    end
  end

  // One copy of the image per neighbour so all four are read together
  for (genvar k = 0; k < NUM_NBR; k++) begin : g_bank
    logic [PIX_W-1:0] mem [MEM_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en) mem[AW'(q_head_i.load_addr)] <= q_head_i.load_val;
      if (adv)   rd_q[k] <= mem[rd_addr[k]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (q_valid_i && !q_head_i.is_load && q_head_i.in_image) begin
        ch_q <= issue_last ? '0 : ch_q + 1'b1;
      end
      t1_q        <= tag0;
      t2_q        <= t1_q;
      t3_q        <= t2_q;
      out_valid_q <= t3_q.valid && t3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q <= q_head_i.fx[FB-1:0];
      fy1_q <= q_head_i.fy[FB-1:0];
      top_q <= HW'(HW'(ONE) - HW'(fx1_q)) * HW'(rd_q[0]) + HW'(fx1_q) * HW'(rd_q[1]);
      bot_q <= HW'(HW'(ONE) - HW'(fx1_q)) * HW'(rd_q[2]) + HW'(fx1_q) * HW'(rd_q[3]);
      fy2_q <= fy1_q;
      v3_q  <= OUT_W'((VW'(VW'(ONE) - VW'(fy2_q)) * VW'(top_q)
                       + VW'(fy2_q) * VW'(bot_q)) >> FB);
      if (t3_q.valid) begin
        acc_q[t3_q.ch] <= v3_q;
        if (t3_q.last) begin
          in_image_q <= t3_q.in_image;
          for (int j = 0; j < NUM_OUT_CH; j++) begin
            if (!t3_q.in_image || j > int'(t3_q.ch)) res_q[j] <= '0;
            else if (j == int'(t3_q.ch))            res_q[j] <= v3_q;
            else                                     res_q[j] <= acc_q[j];
          end
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign channel_0_o  = res_q[0];
  assign channel_1_o  = res_q[1];
  assign channel_2_o  = res_q[2];
  assign channel_3_o  = res_q[3];
  assign inside_res_o = in_image_q;

`ifndef NO_ASSERTIONS
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");
  a_ch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q != '0 |-> {1'b0, ch_q} < cfg_i.count) else $error("channel index past count");
  a_outside_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t1_q.valid && !t1_q.in_image |-> t1_q.last && t1_q.ch == '0)
    else $error("outside sample spans channels");
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && t3_q.valid && t3_q.last |=> out_valid_q) else $error("result lost");
`endif

endmodule

@@ hw/rtl/bilinear_image_sampler_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_sampler_top
// Bilinear image sampler: byte-loaded pixel store, fixed-point sample lookup.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------------
//  input     | in        | in_valid_i / in_stall_o    | action, load_*, sample_x/y
//  output    | out       | out_valid_o / out_stall_i  | channel_0..3, inside_res
//  config    | in        | APB psel/penable/pready    | width, height, channel count
//
//  A load is one byte write; a sample inside the image takes one read per channel
//  (1..4, the channel count), as each neighbour copy of the pixel store has a single
//  read port serving one byte a cycle unless the output stalls. Outside samples
//  leave the queue as one item. Stages: 3 front, queue, 4 back. No clearing pass
//  after reset: the user must read pixel bytes only once written; the block does not
//  enforce it. Input and output stall independently through the 4-entry queue.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_top import bis_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input transfer
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [LADDR_W-1:0]        load_address_i,
  input  logic [PIX_W-1:0]          load_value_i,
  input  logic signed [COORD_W-1:0] sample_x_i,
  input  logic signed [COORD_W-1:0] sample_y_i,
  // output transfer
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OUT_W-1:0]          channel_0_o,
  output logic [OUT_W-1:0]          channel_1_o,
  output logic [OUT_W-1:0]          channel_2_o,
  output logic [OUT_W-1:0]          channel_3_o,
  output logic                      inside_res_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

  logic [DIM_W-1:0] width_q, height_q;
  logic [CNT_W-1:0] count_q;
  cfg_t             cfg;
  reg_idx_e         ridx;
  logic             q_full, q_push, q_pop, q_valid;
  entry_t           q_in, q_head;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  // Register file: written in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      count_q  <= CNT_W'(4);
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_IMAGE_WIDTH:   width_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_q <= pwdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: count_q  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_IMAGE_WIDTH:   prdata = PDATA_W'(width_q);
      REG_IMAGE_HEIGHT:  prdata = PDATA_W'(height_q);
      REG_CHANNEL_COUNT: prdata = PDATA_W'(count_q);
      default:           prdata = '0;
    endcase
  end

  // Saturate registers into the supported ranges
  always_comb begin
    if (width_q == '0)                  cfg.width = DIM_W'(1);
    else if (32'(width_q) > MAX_WIDTH)  cfg.width = DIM_W'(MAX_WIDTH);
    else                                cfg.width = width_q;
    if (height_q == '0)                 cfg.height = DIM_W'(1);
    else if (32'(height_q) > MAX_HEIGHT) cfg.height = DIM_W'(MAX_HEIGHT);
    else                                cfg.height = height_q;
    if (count_q == '0)                  cfg.count = CNT_W'(1);
    else if (32'(count_q) > MAX_CHANNELS) cfg.count = CNT_W'(MAX_CHANNELS);
    else                                cfg.count = count_q;
  end

  bis_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_stall_o, .action_i, .load_address_i, .load_value_i,
    .sample_x_i, .sample_y_i,
    .q_full_i(q_full), .push_o(q_push), .entry_o(q_in)
  );

  bis_queue #(.W($bits(entry_t))) u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .head_o(q_head)
  );

  bis_back #(.FRACTION_BITS(FRACTION_BITS), .MEM_DEPTH(MEM_DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .q_valid_i(q_valid), .q_head_i(q_head), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i,
    .channel_0_o, .channel_1_o, .channel_2_o, .channel_3_o, .inside_res_o
  );

endmodule
